// ----- hdl/pdcq_pkg.sv -----
package pdcq_pkg;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [2:0] {
    EV_QUEUED    = 3'd0,
    EV_EVICTED   = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_DELIVERED = 3'd3,
    EV_EMPTY     = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] number;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  rank;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic decide;
    logic scan;
    logic shift;
    logic tail_write;
    logic deq;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_deq;
    logic discard;
    logic empty;
    logic scan_last;
    logic found;
    logic pos_is_tail;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/pdcq_ctrl.sv -----
module pdcq_ctrl import pdcq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DECIDE     = 8'b0000_0010,
    S_SCAN       = 8'b0000_0100,
    S_SHIFT_LOAD = 8'b0000_1000,
    S_SHIFT      = 8'b0001_0000,
    S_TAIL       = 8'b0010_0000,
    S_DEQ        = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.is_deq) begin
          state_next = sts.empty ? S_FINISH : S_DEQ;
        end else if (sts.discard) begin
          state_next = sts.empty ? S_FINISH : S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          if (!sts.found) state_next = S_FINISH;
          else if (sts.pos_is_tail) state_next = S_TAIL;
          else state_next = S_SHIFT_LOAD;
        end
      end
      S_SHIFT_LOAD: state_next = S_SHIFT;
      S_SHIFT: begin
        if (sts.shift_last) state_next = S_TAIL;
      end
      S_TAIL:   state_next = S_FINISH;
      S_DEQ:    state_next = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.idle       = (state == S_IDLE);
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.decide     = (state == S_DECIDE);
    cmd.scan       = (state == S_SCAN);
    cmd.shift      = (state == S_SHIFT);
    cmd.tail_write = (state == S_TAIL);
    cmd.deq        = (state == S_DEQ);
    cmd.finish     = (state == S_FINISH) && sts.out_free;
  end

endmodule

// ----- hdl/pdcq_datapath.sv -----
module pdcq_datapath import pdcq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        func,
  input  logic [15:0] packet_number,
  input  logic [7:0]  source_address,
  input  logic [7:0]  dest_address,
  input  logic [7:0]  drop_rank,
  input  logic        cfg_valid,
  input  logic [3:0]  congestion_threshold,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [15:0] out_packet_number,
  output logic [7:0]  out_source,
  output logic [7:0]  out_dest,
  output logic [7:0]  out_rank,
  output logic [3:0]  queue_length,
  output logic [3:0]  average_length
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST_C) ? '0 : AW'(i + 1'b1);
  endfunction

  entry_t mem [QUEUE_DEPTH];

  logic          arr_func;
  entry_t        arr;
  logic [3:0]    thr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] sm;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] ptr;
  logic [AW-1:0] data_ptr;
  entry_t        rd_data;
  logic [7:0]    best;
  logic [AW-1:0] pos;
  logic          found;
  entry_t        victim;
  logic [CW-1:0] rem;
  event_t        res_code;
  entry_t        res_entry;

  logic [CW:0]   avg_sum;
  logic [CW-1:0] avg_enq;
  logic [CW-1:0] cnt_dec;
  logic [CW:0]   deq_sum;
  logic [CW-1:0] avg_deq;
  logic          over_thr;
  logic          discard;
  logic          hit;
  logic          found_now;
  logic [AW-1:0] pos_now;
  entry_t        victim_now;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW+3:0] cnt_ext;
  logic [CW+3:0] sm_ext;

  // Enqueue average counts the arrival: floor((avg + count + 1) / 2).
  assign avg_sum  = {1'b0, sm} + {1'b0, cnt} + {{CW{1'b0}}, 1'b1};
  assign avg_enq  = avg_sum[CW:1];
  assign cnt_dec  = cnt - 1'b1;
  assign deq_sum  = {1'b0, sm} + {1'b0, cnt_dec};
  assign avg_deq  = deq_sum[CW:1];
  assign over_thr = ({4'b0, avg_enq} >= {{CW{1'b0}}, thr});
  assign discard  = over_thr || (cnt == DEPTH_C);

  assign hit        = (rd_data.rank > best);
  assign found_now  = found || hit;
  assign pos_now    = hit ? data_ptr : pos;
  assign victim_now = hit ? rd_data : victim;

  always_comb begin
    sts             = '0;
    sts.is_deq      = (arr_func == FUNC_DEQ);
    sts.discard     = discard;
    sts.empty       = (cnt == '0);
    sts.scan_last   = (rem == CW'(1));
    sts.found       = found_now;
    sts.pos_is_tail = (pos_now == tail);
    sts.shift_last  = (ring_next(pos) == tail);
    sts.out_free    = !out_valid || !out_stall;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rd_data;
    if (cmd.decide && arr_func == FUNC_ENQ && !discard) begin
      wr_en   = 1'b1;
      wr_addr = ring_next(tail);
      wr_data = arr;
    end
    if (cmd.shift) begin
      wr_en   = 1'b1;
      wr_addr = pos;
      wr_data = rd_data;
    end
    if (cmd.tail_write) begin
      wr_en   = 1'b1;
      wr_addr = tail;
      wr_data = arr;
    end
  end

  // One write port and one registered read port; reads run one entry
  // ahead of the writes while entries close up behind an eviction.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data  <= mem[ptr];
    data_ptr <= ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= 4'd8;
      cnt  <= '0;
      sm   <= '0;
      head <= '0;
      tail <= LAST_C;
    end else begin
      if (cfg_valid) thr <= congestion_threshold;
      if (cmd.decide && arr_func == FUNC_ENQ) begin
        sm <= avg_enq;
        if (!discard) begin
          cnt  <= cnt + 1'b1;
          tail <= ring_next(tail);
        end
      end
      if (cmd.deq) begin
        head <= ring_next(head);
        cnt  <= cnt_dec;
        sm   <= avg_deq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arr_func   <= func;
      arr.number <= packet_number;
      arr.src    <= source_address;
      arr.dst    <= dest_address;
      arr.rank   <= drop_rank;
    end

    if (cmd.idle) begin
      ptr <= head;
    end else if (cmd.scan && sts.scan_last) begin
      ptr <= ring_next(pos_now);
    end else begin
      ptr <= ring_next(ptr);
    end

    if (cmd.decide) begin
      best  <= arr.rank;
      found <= 1'b0;
      rem   <= cnt;
      if (arr_func == FUNC_DEQ) begin
        res_code  <= EV_EMPTY;
        res_entry <= '0;
      end else if (discard) begin
        res_code  <= EV_DROPPED;
        res_entry <= arr;
      end else begin
        res_code  <= EV_QUEUED;
        res_entry <= '0;
      end
    end

    if (cmd.scan) begin
      rem <= rem - 1'b1;
      if (hit) begin
        best   <= rd_data.rank;
        pos    <= data_ptr;
        found  <= 1'b1;
        victim <= rd_data;
      end
      if (sts.scan_last && found_now) begin
        res_code  <= EV_EVICTED;
        res_entry <= victim_now;
      end
    end

    if (cmd.shift) pos <= ring_next(pos);

    if (cmd.deq) begin
      res_code  <= EV_DELIVERED;
      res_entry <= rd_data;
    end

    if (cmd.finish) begin
      event_code        <= res_code;
      out_packet_number <= res_entry.number;
      out_source        <= res_entry.src;
      out_dest          <= res_entry.dst;
      out_rank          <= res_entry.rank;
      queue_length      <= cnt_ext[3:0];
      average_length    <= sm_ext[3:0];
    end
  end

  assign cnt_ext = {4'b0, cnt};
  assign sm_ext  = {4'b0, sm};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/priority_drop_congestion_queue.sv -----
// Packet queue with congestion discard. Each beat on the input channel is
// either an enqueue or a dequeue and yields exactly one result beat. An
// enqueue updates the smoothed length; when that average reaches the
// threshold, or the queue is full, the held entries are scanned from the
// head for the first entry of highest rank strictly above the arrival's,
// that entry is evicted and reported, later entries close up in order and
// the arrival goes to the tail; with no such entry the arrival is dropped.
// Items are handled one at a time, and all entries sit in a single memory
// with one read and one write port. A beat is captured, then decided; a
// congested enqueue then scans every held entry and, on an eviction,
// closes up the entries behind the evicted one and writes the arrival at
// the tail; a delivering dequeue reads the head entry; each beat ends when
// its result is loaded into the output register.
// The result sits in an output register, so the next beat is taken while
// the previous result is still waiting. The threshold register resets to 8
// and should be written only while no beat is in flight.
module priority_drop_congestion_queue import pdcq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] packet_number,
  input  logic [7:0]  source_address,
  input  logic [7:0]  dest_address,
  input  logic [7:0]  drop_rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [15:0] out_packet_number,
  output logic [7:0]  out_source,
  output logic [7:0]  out_dest,
  output logic [7:0]  out_rank,
  output logic [3:0]  queue_length,
  output logic [3:0]  average_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  congestion_threshold
);

  cmd_t cmd;
  sts_t sts;

  // The threshold register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  pdcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdcq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .func                 (func),
    .packet_number        (packet_number),
    .source_address       (source_address),
    .dest_address         (dest_address),
    .drop_rank            (drop_rank),
    .cfg_valid            (cfg_valid),
    .congestion_threshold (congestion_threshold),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .event_code           (event_code),
    .out_packet_number    (out_packet_number),
    .out_source           (out_source),
    .out_dest             (out_dest),
    .out_rank             (out_rank),
    .queue_length         (queue_length),
    .average_length       (average_length)
  );

endmodule
